// ===== rtl/core/tps_pkg.sv =====
// shared types, constants and case tables for the triangle plane splitter
package tps_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int NORMAL_WIDTH_DEF = 16;
  localparam int THR_WIDTH        = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int Q_WIDTH          = 17;
  localparam int DIV_STEPS        = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NRM_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NRM_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NRM_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 3'd6;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DOT, ST_DOT_END, ST_EDGE_LD, ST_EDGE_CHK, ST_DIV,
    ST_INTERP, ST_IP_END, ST_DECIDE, ST_EMIT_LD, ST_EMIT_WAIT
  } state_t;

  typedef enum logic [2:0] {
    CS_NONE, CS_WHOLE, CS_Z2, CS_Z0, CS_Z1, CS_C0, CS_C1, CS_C2
  } case_t;

  typedef enum logic [1:0] {
    EA_SKIP, EA_FULL, EA_DIV
  } edge_act_t;

  typedef struct packed {
    logic       load_vtx;
    logic [1:0] slot;
    logic       dot_go;
    logic       edge_ld;
    logic       edge_chk;
    logic       div_step;
    logic       ip_go;
    logic       decide;
    logic       emit_ld;
    logic [1:0] vsel;
    logic [1:0] asel;
    logic [1:0] esel;
    logic [3:0] kidx;
  } cmd_t;

  typedef struct packed {
    logic       zero_nrm;
    edge_act_t  edge_act;
    logic [3:0] count;
  } sts_t;

  // entry is {position source, normal source}; positions 3..5 are edge crossings
  localparam logic [4:0] PICK_TAB [8][9] = '{
    '{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{{3'd0,2'd0}, {3'd1,2'd1}, {3'd2,2'd2}, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
    '{{3'd2,2'd0}, {3'd0,2'd0}, {3'd3,2'd0}, {3'd1,2'd0}, {3'd2,2'd0}, {3'd3,2'd0},
      5'd0, 5'd0, 5'd0},
    '{{3'd0,2'd0}, {3'd1,2'd0}, {3'd4,2'd0}, {3'd2,2'd0}, {3'd0,2'd0}, {3'd4,2'd0},
      5'd0, 5'd0, 5'd0},
    '{{3'd1,2'd0}, {3'd2,2'd0}, {3'd5,2'd0}, {3'd0,2'd0}, {3'd1,2'd0}, {3'd5,2'd0},
      5'd0, 5'd0, 5'd0},
    '{{3'd0,2'd0}, {3'd1,2'd1}, {3'd5,2'd0}, {3'd1,2'd1}, {3'd4,2'd0}, {3'd5,2'd0},
      {3'd5,2'd0}, {3'd4,2'd0}, {3'd2,2'd2}},
    '{{3'd2,2'd0}, {3'd0,2'd0}, {3'd4,2'd0}, {3'd0,2'd0}, {3'd3,2'd0}, {3'd4,2'd0},
      {3'd4,2'd0}, {3'd3,2'd0}, {3'd1,2'd0}},
    '{{3'd1,2'd0}, {3'd2,2'd0}, {3'd3,2'd0}, {3'd2,2'd0}, {3'd5,2'd0}, {3'd3,2'd0},
      {3'd3,2'd0}, {3'd5,2'd0}, {3'd0,2'd0}}
  };

  function automatic logic [3:0] case_count(case_t c);
    logic [3:0] n;
    unique case (c)
      CS_NONE:                n = 4'd0;
      CS_WHOLE:               n = 4'd3;
      CS_Z2, CS_Z0, CS_Z1:    n = 4'd6;
      default:                n = 4'd9;
    endcase
    return n;
  endfunction

  function automatic logic [3:0] case_split(case_t c);
    logic [3:0] n;
    unique case (c)
      CS_C0, CS_C1, CS_C2: n = 4'd6;
      default:             n = 4'd3;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/core/tps_if.sv =====
// channel interfaces: vertex in, vertex out, register write
interface tps_in_if #(
  parameter int CW = tps_pkg::COORD_WIDTH_DEF,
  parameter int NW = tps_pkg::NORMAL_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] vertex_pos_x;
  logic signed [CW-1:0] vertex_pos_y;
  logic signed [CW-1:0] vertex_pos_z;
  logic signed [NW-1:0] vertex_nrm_x;
  logic signed [NW-1:0] vertex_nrm_y;
  logic signed [NW-1:0] vertex_nrm_z;
  modport source (output valid, vertex_pos_x, vertex_pos_y, vertex_pos_z,
                  vertex_nrm_x, vertex_nrm_y, vertex_nrm_z, input ready);
  modport sink (input valid, vertex_pos_x, vertex_pos_y, vertex_pos_z,
                vertex_nrm_x, vertex_nrm_y, vertex_nrm_z, output ready);
endinterface

interface tps_out_if #(
  parameter int CW = tps_pkg::COORD_WIDTH_DEF,
  parameter int NW = tps_pkg::NORMAL_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_pos_x;
  logic signed [CW-1:0] out_pos_y;
  logic signed [CW-1:0] out_pos_z;
  logic signed [NW-1:0] out_nrm_x;
  logic signed [NW-1:0] out_nrm_y;
  logic signed [NW-1:0] out_nrm_z;
  logic                 side;
  logic                 last_of_run;
  modport source (output valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                  out_nrm_z, side, last_of_run, input ready);
  modport sink (input valid, out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
                out_nrm_z, side, last_of_run, output ready);
endinterface

interface tps_cfg_if #(
  parameter int CW = tps_pkg::COORD_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [tps_pkg::CFG_IDX_W-1:0]  index;
  logic [CW-1:0]                  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/tps_ctrl.sv =====
// sequencer: vertex phase, dot product, edge crossings, emission
module tps_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  tps_pkg::sts_t sts,
  output tps_pkg::cmd_t cmd
);

  tps_pkg::state_t state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [1:0] vtx_r, vtx_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic [1:0] edge_r, edge_nxt;
  logic [3:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tps_pkg::ST_IDLE;
      phase_r <= 2'd0;
      vtx_r   <= 2'd0;
      ax_r    <= 2'd0;
      edge_r  <= 2'd0;
      cnt_r   <= 4'd0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      vtx_r   <= vtx_nxt;
      ax_r    <= ax_nxt;
      edge_r  <= edge_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign out_valid = (state_r == tps_pkg::ST_EMIT_WAIT);

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    vtx_nxt   = vtx_r;
    ax_nxt    = ax_r;
    edge_nxt  = edge_r;
    cnt_nxt   = cnt_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.vsel  = vtx_r;
    cmd.asel  = ax_r;
    cmd.esel  = edge_r;
    cmd.kidx  = cnt_r;
    unique case (state_r)
      tps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_vtx = 1'b1;
          cmd.slot     = (phase_r >= 2'd2) ? 2'd2 : phase_r;
          if (phase_r >= 2'd2) begin
            phase_nxt = 2'd0;
            vtx_nxt   = 2'd0;
            ax_nxt    = 2'd0;
            if (!sts.zero_nrm) state_nxt = tps_pkg::ST_DOT;
          end else begin
            phase_nxt = phase_r + 2'd1;
          end
        end
      end
      tps_pkg::ST_DOT: begin
        cmd.dot_go = 1'b1;
        if (ax_r == 2'd2) begin
          ax_nxt = 2'd0;
          if (vtx_r == 2'd2) state_nxt = tps_pkg::ST_DOT_END;
          else vtx_nxt = vtx_r + 2'd1;
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
      tps_pkg::ST_DOT_END: begin
        edge_nxt  = 2'd0;
        state_nxt = tps_pkg::ST_EDGE_LD;
      end
      tps_pkg::ST_EDGE_LD: begin
        cmd.edge_ld = 1'b1;
        state_nxt   = tps_pkg::ST_EDGE_CHK;
      end
      tps_pkg::ST_EDGE_CHK: begin
        cmd.edge_chk = 1'b1;
        ax_nxt       = 2'd0;
        cnt_nxt      = 4'd0;
        unique case (sts.edge_act)
          tps_pkg::EA_FULL: state_nxt = tps_pkg::ST_INTERP;
          tps_pkg::EA_DIV:  state_nxt = tps_pkg::ST_DIV;
          default: begin
            if (edge_r == 2'd2) begin
              state_nxt = tps_pkg::ST_DECIDE;
            end else begin
              edge_nxt  = edge_r + 2'd1;
              state_nxt = tps_pkg::ST_EDGE_LD;
            end
          end
        endcase
      end
      tps_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == 4'(tps_pkg::DIV_STEPS - 1)) state_nxt = tps_pkg::ST_INTERP;
        else cnt_nxt = cnt_r + 4'd1;
      end
      tps_pkg::ST_INTERP: begin
        cmd.ip_go = 1'b1;
        if (ax_r == 2'd2) state_nxt = tps_pkg::ST_IP_END;
        else ax_nxt = ax_r + 2'd1;
      end
      tps_pkg::ST_IP_END: begin
        if (edge_r == 2'd2) begin
          state_nxt = tps_pkg::ST_DECIDE;
        end else begin
          edge_nxt  = edge_r + 2'd1;
          state_nxt = tps_pkg::ST_EDGE_LD;
        end
      end
      tps_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        cnt_nxt    = 4'd0;
        state_nxt  = tps_pkg::ST_EMIT_LD;
      end
      tps_pkg::ST_EMIT_LD: begin
        if (sts.count == 4'd0) begin
          state_nxt = tps_pkg::ST_IDLE;
        end else begin
          cmd.emit_ld = 1'b1;
          state_nxt   = tps_pkg::ST_EMIT_WAIT;
        end
      end
      tps_pkg::ST_EMIT_WAIT: begin
        if (out_ready) begin
          if (cnt_r == sts.count - 4'd1) begin
            state_nxt = tps_pkg::ST_IDLE;
          end else begin
            cnt_nxt   = cnt_r + 4'd1;
            state_nxt = tps_pkg::ST_EMIT_LD;
          end
        end
      end
      default: state_nxt = tps_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/tps_datapath.sv =====
// plane registers, held vertices, plane distances, crossing divider and output register
module tps_datapath #(
  parameter int CW = tps_pkg::COORD_WIDTH_DEF,
  parameter int NW = tps_pkg::NORMAL_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [CW-1:0]                   cfg_data,
  input  logic signed [CW-1:0]            in_pos [3],
  input  logic signed [NW-1:0]            in_nrm [3],
  input  tps_pkg::cmd_t                   cmd,
  output tps_pkg::sts_t                   sts,
  output logic signed [CW-1:0]            out_pos [3],
  output logic signed [NW-1:0]            out_nrm [3],
  output logic                            out_side,
  output logic                            out_last
);

  localparam int DW = CW + 1;          // position difference
  localparam int PW = DW + CW;         // dot product term
  localparam int SW = 2 * CW + 2;      // plane distance
  localparam int AW = SW + 1;          // crossing numerator and denominator
  localparam int QW = tps_pkg::Q_WIDTH;
  localparam int IW = QW + 1 + DW;     // interpolation product

  logic signed [CW-1:0] org_r [3];
  logic signed [CW-1:0] pn_r [3];
  logic [tps_pkg::THR_WIDTH-1:0] thr_r;

  logic signed [CW-1:0] vpos_r [3][3];
  logic signed [NW-1:0] vnrm_r [3][3];
  logic signed [CW-1:0] xpos_r [3][3];
  logic                 cross_r [3];
  logic signed [SW-1:0] s_r [3];
  logic signed [SW-1:0] acc_r;
  logic signed [PW-1:0] prod_r;
  logic                 pvld_r;
  logic [1:0]           pvtx_r, pax_r;

  logic signed [AW-1:0] n_r, d_r;
  logic [AW-1:0]        ad_r, rem_r;
  logic [QW-1:0]        q_r;

  logic signed [IW-1:0] ipr_r;
  logic signed [CW-1:0] ipa_r;
  logic                 ipv_r;
  logic [1:0]           ipax_r, ipe_r;

  tps_pkg::case_t case_r;
  logic           fs_r;

  // plane registers: reset values and configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      pn_r[0]  <= '0;
      pn_r[1]  <= '0;
      pn_r[2]  <= CW'(65536);
      thr_r    <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tps_pkg::REG_ORG_X: org_r[0] <= cfg_data;
        tps_pkg::REG_ORG_Y: org_r[1] <= cfg_data;
        tps_pkg::REG_ORG_Z: org_r[2] <= cfg_data;
        tps_pkg::REG_NRM_X: pn_r[0]  <= cfg_data;
        tps_pkg::REG_NRM_Y: pn_r[1]  <= cfg_data;
        tps_pkg::REG_NRM_Z: pn_r[2]  <= cfg_data;
        tps_pkg::REG_THR:   thr_r    <= cfg_data[tps_pkg::THR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // dot product: one term a cycle, accumulated in the following cycle
  logic signed [DW-1:0] dot_diff;
  logic signed [PW-1:0] dot_prod;
  logic signed [SW-1:0] acc_sum;
  assign dot_diff = DW'(vpos_r[cmd.vsel][cmd.asel]) - DW'(org_r[cmd.asel]);
  assign dot_prod = dot_diff * pn_r[cmd.asel];
  assign acc_sum  = acc_r + SW'(prod_r);

  // edge endpoints
  logic [1:0] ea, eb;
  always_comb begin
    unique case (cmd.esel)
      2'd0:    begin ea = 2'd0; eb = 2'd1; end
      2'd1:    begin ea = 2'd1; eb = 2'd2; end
      default: begin ea = 2'd2; eb = 2'd0; end
    endcase
  end

  logic [AW-1:0] an_c, ad_c;
  logic          par_c, bad_c;
  assign an_c  = n_r[AW-1] ? AW'(-n_r) : AW'(n_r);
  assign ad_c  = d_r[AW-1] ? AW'(-d_r) : AW'(d_r);
  assign par_c = ad_c < AW'(thr_r);
  assign bad_c = ((n_r != '0) && (n_r[AW-1] != d_r[AW-1])) || (ad_c < an_c);

  assign sts.edge_act = (par_c || bad_c) ? tps_pkg::EA_SKIP :
                        (an_c >= ad_c)   ? tps_pkg::EA_FULL : tps_pkg::EA_DIV;
  assign sts.zero_nrm = (pn_r[0] == '0) && (pn_r[1] == '0) && (pn_r[2] == '0);
  assign sts.count    = tps_pkg::case_count(case_r);

  logic [AW:0] rem_sh;
  assign rem_sh = {rem_r, 1'b0};

  logic signed [DW-1:0] ip_u;
  logic signed [IW-1:0] ip_sum;
  assign ip_u   = DW'(vpos_r[eb][cmd.asel]) - DW'(vpos_r[ea][cmd.asel]);
  assign ip_sum = IW'(ipa_r) + (ipr_r >>> 16);

  // side classification
  logic       sp [3], sn [3], sz [3];
  logic [1:0] cp, cn, cz;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sz[i] = (s_r[i] == '0);
      sn[i] = s_r[i][SW-1];
      sp[i] = !sz[i] && !sn[i];
    end
    cp = 2'(sp[0]) + 2'(sp[1]) + 2'(sp[2]);
    cn = 2'(sn[0]) + 2'(sn[1]) + 2'(sn[2]);
    cz = 2'(sz[0]) + 2'(sz[1]) + 2'(sz[2]);
  end

  tps_pkg::case_t case_c;
  logic           fs_c;
  always_comb begin
    case_c = tps_pkg::CS_NONE;
    fs_c   = 1'b0;
    priority if (cp == 2'd3 || (cz == 2'd2 && cp == 2'd1) || (cz == 2'd1 && cp == 2'd2)) begin
      case_c = tps_pkg::CS_WHOLE;
    end else if (cn == 2'd3 || (cz == 2'd2 && cn == 2'd1) ||
                 (cz == 2'd1 && cn == 2'd2)) begin
      case_c = tps_pkg::CS_WHOLE;
      fs_c   = 1'b1;
    end else if (cz == 2'd1 && sz[2]) begin
      case_c = tps_pkg::CS_Z2;
      fs_c   = sn[0];
    end else if (cz == 2'd1 && sz[0]) begin
      case_c = tps_pkg::CS_Z0;
      fs_c   = !sp[1];
    end else if (cz == 2'd1 && sz[1]) begin
      case_c = tps_pkg::CS_Z1;
      fs_c   = sp[0];
    end else if (cz == 2'd0 && (cp == 2'd2 || cn == 2'd2)) begin
      fs_c = (cn == 2'd2);
      priority if (cross_r[1] && cross_r[2]) case_c = tps_pkg::CS_C0;
      else if (cross_r[1] && cross_r[0])     case_c = tps_pkg::CS_C1;
      else if (cross_r[2] && cross_r[0])     case_c = tps_pkg::CS_C2;
      else                                   case_c = tps_pkg::CS_NONE;
    end else begin
      case_c = tps_pkg::CS_NONE;
    end
  end

  logic [4:0] pick;
  logic [2:0] psrc;
  logic [1:0] nsrc;
  assign pick = tps_pkg::PICK_TAB[case_r][cmd.kidx];
  assign psrc = pick[4:2];
  assign nsrc = pick[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      ipv_r  <= 1'b0;
      acc_r  <= '0;
    end else begin
      pvld_r <= cmd.dot_go;
      ipv_r  <= cmd.ip_go;
      if (pvld_r) begin
        if (pax_r == 2'd2) begin
          s_r[pvtx_r] <= acc_sum;
          acc_r       <= '0;
        end else begin
          acc_r <= acc_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vtx) begin
      vpos_r[cmd.slot][0] <= in_pos[0];
      vpos_r[cmd.slot][1] <= in_pos[1];
      vpos_r[cmd.slot][2] <= in_pos[2];
      vnrm_r[cmd.slot][0] <= in_nrm[0];
      vnrm_r[cmd.slot][1] <= in_nrm[1];
      vnrm_r[cmd.slot][2] <= in_nrm[2];
    end
    prod_r <= dot_prod;
    pvtx_r <= cmd.vsel;
    pax_r  <= cmd.asel;

    if (cmd.edge_ld) begin
      n_r <= -AW'(s_r[ea]);
      d_r <= AW'(s_r[eb]) - AW'(s_r[ea]);
    end
    if (cmd.edge_chk) begin
      rem_r <= an_c;
      ad_r  <= ad_c;
      unique case (sts.edge_act)
        tps_pkg::EA_FULL: begin
          q_r                <= QW'(65536);
          cross_r[cmd.esel]  <= 1'b1;
        end
        tps_pkg::EA_DIV: begin
          q_r                <= '0;
          cross_r[cmd.esel]  <= 1'b1;
        end
        default: begin
          cross_r[cmd.esel]   <= 1'b0;
          xpos_r[cmd.esel][0] <= '0;
          xpos_r[cmd.esel][1] <= '0;
          xpos_r[cmd.esel][2] <= '0;
        end
      endcase
    end
    // restoring division, one quotient bit a cycle
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, ad_r}) begin
        rem_r <= AW'(rem_sh - {1'b0, ad_r});
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[AW-1:0];
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
    end

    ipr_r  <= $signed({1'b0, q_r}) * ip_u;
    ipa_r  <= vpos_r[ea][cmd.asel];
    ipax_r <= cmd.asel;
    ipe_r  <= cmd.esel;
    if (ipv_r) xpos_r[ipe_r][ipax_r] <= ip_sum[CW-1:0];

    if (cmd.decide) begin
      case_r <= case_c;
      fs_r   <= fs_c;
    end

    if (cmd.emit_ld) begin
      for (int i = 0; i < 3; i++) begin
        out_pos[i] <= (psrc < 3'd3) ? vpos_r[psrc[1:0]][i] : xpos_r[2'(psrc - 3'd3)][i];
        out_nrm[i] <= vnrm_r[nsrc][i];
      end
      out_side <= (cmd.kidx < tps_pkg::case_split(case_r)) ? fs_r : !fs_r;
      out_last <= (cmd.kidx == tps_pkg::case_count(case_r) - 4'd1);
    end
  end

endmodule

// ===== rtl/core/triangle_plane_splitter.sv =====
// after the third vertex: a 9-term dot product, then per edge a check, a restoring division
// when the crossing lies before the far end, and interpolation; then emission
// vertices are taken only while idle; a triangle emits 0, 3, 6 or 9 vertices;
// one triangle at a time; a zero plane normal drops the triangle with no output
// reset: synchronous active-low rst_n clears the sequencer and vertex phase and loads the
// plane registers with origin zero, normal (0,0,1.0) and threshold 1
module triangle_plane_splitter #(
  parameter int COORD_WIDTH  = tps_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_WIDTH = tps_pkg::NORMAL_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  tps_in_if.sink      in_vtx,
  tps_out_if.source   out_vtx,
  tps_cfg_if.sink     cfg_wr
);

  tps_pkg::cmd_t cmd;
  tps_pkg::sts_t sts;

  logic signed [COORD_WIDTH-1:0]  in_pos [3];
  logic signed [NORMAL_WIDTH-1:0] in_nrm [3];
  logic signed [COORD_WIDTH-1:0]  o_pos [3];
  logic signed [NORMAL_WIDTH-1:0] o_nrm [3];

  assign in_pos[0] = in_vtx.vertex_pos_x;
  assign in_pos[1] = in_vtx.vertex_pos_y;
  assign in_pos[2] = in_vtx.vertex_pos_z;
  assign in_nrm[0] = in_vtx.vertex_nrm_x;
  assign in_nrm[1] = in_vtx.vertex_nrm_y;
  assign in_nrm[2] = in_vtx.vertex_nrm_z;

  assign cfg_wr.ready = 1'b1;

  tps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_vtx.valid),
    .in_ready  (in_vtx.ready),
    .out_valid (out_vtx.valid),
    .out_ready (out_vtx.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tps_datapath #(
    .CW (COORD_WIDTH),
    .NW (NORMAL_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_wr.valid),
    .cfg_index (cfg_wr.index),
    .cfg_data  (cfg_wr.data),
    .in_pos    (in_pos),
    .in_nrm    (in_nrm),
    .cmd       (cmd),
    .sts       (sts),
    .out_pos   (o_pos),
    .out_nrm   (o_nrm),
    .out_side  (out_vtx.side),
    .out_last  (out_vtx.last_of_run)
  );

  assign out_vtx.out_pos_x = o_pos[0];
  assign out_vtx.out_pos_y = o_pos[1];
  assign out_vtx.out_pos_z = o_pos[2];
  assign out_vtx.out_nrm_x = o_nrm[0];
  assign out_vtx.out_nrm_y = o_nrm[1];
  assign out_vtx.out_nrm_z = o_nrm[2];

endmodule

// ===== rtl/core/tps_checker.sv =====
// port-level checks for the triangle plane splitter, bound to the top level
module tps_assertions (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // no new vertex is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready && out_valid))
    else $error("vertex taken during emission");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // the last transaction of a triangle ends the burst
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("result offered after last of run");

endmodule

bind triangle_plane_splitter tps_assertions u_tps_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_vtx.valid),
  .in_ready  (in_vtx.ready),
  .out_valid (out_vtx.valid),
  .out_ready (out_vtx.ready),
  .out_last  (out_vtx.last_of_run)
);
